// ===== hdl/thermistor_adc_temperature_macros.svh =====
// Assertion macros used by the thad_ctrl module of the thermistor temperature block.
`ifndef THERMISTOR_ADC_TEMPERATURE_MACROS_SVH
`define THERMISTOR_ADC_TEMPERATURE_MACROS_SVH

// A property that holds at every clock edge out of reset.
`define THAD_ASSERT_HOLD(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// A condition that must be followed by another in the next cycle.
`define THAD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/thad_pkg.sv =====
package thad_pkg;

    localparam logic [7:0]  SAMPLES_PER_SOURCE = 8'd20;
    localparam logic [35:0] RES_MAX    = 36'hF_FFFF_FFFF;
    localparam logic [25:0] TEMP_MAX   = 26'h3FF_FFFF;
    localparam logic [39:0] LN2_Q30    = 40'd744261118;
    localparam logic [19:0] REF_RESET  = 20'd64900;
    localparam logic [63:0] D_SMALL    = 64'h0000_0040_0000_0000;
    localparam logic [6:0]  RDIV_STEPS = 7'd44;
    localparam logic [6:0]  TDIV_STEPS = 7'd26;
    localparam logic [4:0]  SQ_LAST    = 5'd23;

    typedef enum logic [1:0] {
        CFG_REF = 2'd0,
        CFG_A   = 2'd1,
        CFG_B   = 2'd2,
        CFG_C   = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        SH_0  = 2'd0,
        SH_24 = 2'd1,
        SH_30 = 2'd2
    } sh_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_ACCEPT, OP_CHECK, OP_RMUL, OP_RDIV, OP_RSAT, OP_NORM,
        OP_SQLOAD, OP_SQ, OP_LN, OP_L2, OP_L3, OP_BL, OP_CL, OP_SUM,
        OP_TDIV, OP_TSTORE, OP_OUT
    } op_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_CHECK, ST_RMUL, ST_RMUL_W, ST_RDIV, ST_RDIV_W, ST_RSAT,
        ST_NORM, ST_SQLOAD, ST_SQ, ST_LN, ST_LN_W, ST_L2, ST_L2_W, ST_L3,
        ST_L3_W, ST_BL, ST_BL_W, ST_CL, ST_CL_W, ST_SUM, ST_TDIV, ST_TDIV_W,
        ST_TSTORE, ST_OUT
    } state_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic skip;
        logic mul_busy;
        logic div_busy;
        logic r_zero;
        logic norm_done;
        logic sq_last;
        logic d_done;
        logic out_free;
    } sts_t;

    function automatic logic [63:0] mag64(input logic [63:0] v);
        mag64 = v[63] ? (~v + 64'd1) : v;
    endfunction

    function automatic logic [47:0] mag48(input logic [47:0] v);
        mag48 = v[47] ? (~v + 48'd1) : v;
    endfunction

endpackage

// ===== hdl/thermistor_adc_temperature.sv =====
// Channel  Direction  Payload
// s_       in         tuser: bus_ok; tdata: status_low, adc_sample
// m_       out        tuser: channel_read, next_channel;
//                     tdata: reading_ok, resistance, temperature, temperature_valid
// cfg_     in         cfg_index: register, cfg_data: value
//
// One beat is processed at a time; a rejected or priming beat goes from the check state straight to the output state.
// A full computation runs a 44-step resistance divide, a normalize by left
// shifts, 24 log squarings, six multiplies and a 26-step reciprocal divide.
// Reset is synchronous and active low; configuration writes are always taken.
// A result that is not taken holds the next beat's completion until it is.
module thermistor_adc_temperature (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] status_low, [23:8] adc_sample
    input  logic [0:0]  s_tuser,   // [0] bus_ok
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [0] reading_ok, [36:1] resistance,
                                   // [62:37] temperature, [63] temperature_valid
    output logic [1:0]  m_tuser,   // [0] channel_read, [1] next_channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [47:0] cfg_data
);

    thad_pkg::cmd_t cmd;
    thad_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    thad_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    thad_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// ===== hdl/thad_mul.sv =====
module thad_mul (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                go,
    input  logic [47:0]         a_mag,
    input  logic [39:0]         b_mag,
    input  logic                neg,
    input  thad_pkg::sh_t       sh,
    output logic                busy,
    output logic signed [63:0]  res
);

    logic [47:0]   a_reg;
    logic [39:0]   b_reg;
    logic          neg_reg;
    thad_pkg::sh_t sh_reg;
    logic [87:0]   acc_reg;
    logic [1:0]    cnt_reg;
    logic          busy_reg;
    logic [55:0]   part;
    logic [63:0]   sv;
    logic [63:0]   m;

    assign part = a_reg[47:32] * b_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else if (go) begin
            a_reg    <= a_mag;
            b_reg    <= b_mag;
            neg_reg  <= neg;
            sh_reg   <= sh;
            acc_reg  <= 88'd0;
            cnt_reg  <= 2'd0;
            busy_reg <= 1'b1;
        end else if (busy_reg) begin
            acc_reg <= {acc_reg[71:0], 16'd0} + {32'd0, part};
            a_reg   <= {a_reg[31:0], 16'd0};
            cnt_reg <= cnt_reg + 2'd1;
            if (cnt_reg == 2'd2) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        case (sh_reg)
            thad_pkg::SH_24: sv = acc_reg[87:24];
            thad_pkg::SH_30: sv = {6'd0, acc_reg[87:30]};
            default:         sv = acc_reg[63:0];
        endcase
        m   = {1'b0, sv[62:0]};
        res = neg_reg ? -$signed(m) : $signed(m);
    end

    assign busy = busy_reg;

endmodule

// ===== hdl/thad_div.sv =====
module thad_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        go,
    input  logic [63:0] rem_init,
    input  logic [63:0] dvd,
    input  logic [63:0] dsr,
    input  logic [6:0]  steps,
    output logic        busy,
    output logic [63:0] quo
);

    logic [63:0] rem_reg;
    logic [63:0] dvd_reg;
    logic [63:0] dsr_reg;
    logic [63:0] quo_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic [63:0] trial;
    logic        ge;

    assign trial = {rem_reg[62:0], dvd_reg[63]};
    assign ge    = trial >= dsr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= 7'd0;
        end else if (go) begin
            rem_reg  <= rem_init;
            dvd_reg  <= dvd;
            dsr_reg  <= dsr;
            quo_reg  <= 64'd0;
            cnt_reg  <= steps;
            busy_reg <= 1'b1;
        end else if (busy_reg) begin
            rem_reg <= ge ? (trial - dsr_reg) : trial;
            quo_reg <= {quo_reg[62:0], ge};
            dvd_reg <= {dvd_reg[62:0], 1'b0};
            cnt_reg <= cnt_reg - 7'd1;
            if (cnt_reg == 7'd1) begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign busy = busy_reg;
    assign quo  = quo_reg;

endmodule

// ===== hdl/thad_dp.sv =====
module thad_dp (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  thad_pkg::cmd_t       cmd,
    output thad_pkg::sts_t       sts,
    input  logic [0:0]           s_tuser,
    input  logic [23:0]          s_tdata,
    input  logic                 cfg_valid,
    input  logic [1:0]           cfg_index,
    input  logic [47:0]          cfg_data,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [63:0]          m_tdata,
    output logic [1:0]           m_tuser
);

    logic [19:0] ref_reg;
    logic [47:0] ca_reg, cb_reg, cc_reg;
    logic        priming_reg, pend_reg;
    logic [7:0]  run_reg;
    logic [23:0] src_reg;
    logic [15:0] therm_reg;
    logic [35:0] res_reg;
    logic [25:0] temp_reg;
    logic        valid_reg;
    logic        ok_reg, chan_reg, next_reg, compute_reg;
    logic [35:0] x_reg;
    logic [5:0]  k_reg;
    logic [31:0] m_reg;
    logic [23:0] frac_reg;
    logic [4:0]  sqcnt_reg;
    logic [63:0] l_reg, l3_reg, p1_reg, d_reg;
    logic        mv_reg;
    logic [63:0] mdata_reg;
    logic [1:0]  muser_reg;

    logic        in_ok;
    logic [15:0] sample;
    logic [7:0]  run_next;
    logic [24:0] avg_sum;
    logic [23:0] therm8;
    logic        t_zero, s_le;
    logic [35:0] r16;
    logic [63:0] sq;
    logic [31:0] sq_t;
    logic [7:0]  lg_hi;
    logic [31:0] lg;
    logic [31:0] lg_mag;
    logic [63:0] res_mag, l_mag, l3_mag;
    logic [63:0] d_next;
    logic        d_nonpos, d_small;

    logic        mul_go, mul_busy, mul_neg;
    logic [47:0] mul_a;
    logic [39:0] mul_b;
    thad_pkg::sh_t mul_sh;
    logic signed [63:0] mul_res;
    logic        div_go, div_busy;
    logic [63:0] div_rem, div_dvd, div_dsr, div_quo;
    logic [6:0]  div_steps;

    assign in_ok    = s_tuser[0] & s_tdata[7];
    assign sample   = s_tdata[23:8];
    assign run_next = pend_reg ? run_reg : run_reg + 8'd1;
    assign avg_sum  = {1'b0, src_reg} + {1'b0, sample, 8'd0};
    assign therm8   = {therm_reg, 8'd0};
    assign t_zero   = (therm_reg == 16'd0);
    assign s_le     = (src_reg <= therm8);
    assign r16      = (div_quo[63:36] != 28'd0) ? thad_pkg::RES_MAX : div_quo[35:0];
    assign sq       = m_reg * m_reg;
    assign sq_t     = sq[61:30];
    assign lg_hi    = {2'b00, k_reg} - 8'd4;
    assign lg       = {lg_hi, frac_reg};
    assign lg_mag   = lg[31] ? (~lg + 32'd1) : lg;
    assign res_mag  = thad_pkg::mag64(mul_res);
    assign l_mag    = thad_pkg::mag64(l_reg);
    assign l3_mag   = thad_pkg::mag64(l3_reg);
    assign d_next   = {{16{ca_reg[47]}}, ca_reg} + p1_reg + mul_res;
    assign d_nonpos = d_next[63] || (d_next == 64'd0);
    assign d_small  = (d_next <= thad_pkg::D_SMALL);

    always_comb begin
        mul_go    = 1'b1;
        mul_a     = 48'd0;
        mul_b     = 40'd0;
        mul_neg   = 1'b0;
        mul_sh    = thad_pkg::SH_24;
        div_go    = 1'b1;
        div_rem   = 64'd0;
        div_dvd   = 64'd0;
        div_dsr   = d_reg;
        div_steps = thad_pkg::TDIV_STEPS;
        unique case (cmd.op)
            thad_pkg::OP_RMUL: begin
                mul_a  = {28'd0, ref_reg};
                mul_b  = {16'd0, src_reg - therm8};
                mul_sh = thad_pkg::SH_0;
            end
            thad_pkg::OP_LN: begin
                mul_a   = {16'd0, lg_mag};
                mul_b   = thad_pkg::LN2_Q30;
                mul_neg = lg[31];
                mul_sh  = thad_pkg::SH_30;
            end
            thad_pkg::OP_L2: begin
                mul_a = res_mag[47:0];
                mul_b = res_mag[39:0];
            end
            thad_pkg::OP_L3: begin
                mul_a   = mul_res[47:0];
                mul_b   = l_mag[39:0];
                mul_neg = l_reg[63];
            end
            thad_pkg::OP_BL: begin
                mul_a   = thad_pkg::mag48(cb_reg);
                mul_b   = l_mag[39:0];
                mul_neg = cb_reg[47] ^ l_reg[63];
            end
            thad_pkg::OP_CL: begin
                mul_a   = thad_pkg::mag48(cc_reg);
                mul_b   = l3_mag[39:0];
                mul_neg = cc_reg[47] ^ l3_reg[63];
            end
            default: begin
                mul_go = 1'b0;
            end
        endcase
        unique case (cmd.op)
            thad_pkg::OP_RDIV: begin
                div_dvd   = {mul_res[43:0], 20'd0};
                div_dsr   = {44'd0, therm_reg, 4'd0};
                div_steps = thad_pkg::RDIV_STEPS;
            end
            thad_pkg::OP_TDIV: begin
                div_rem = thad_pkg::D_SMALL;
            end
            default: begin
                div_go = 1'b0;
            end
        endcase
    end

    thad_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .go      (mul_go),
        .a_mag   (mul_a),
        .b_mag   (mul_b),
        .neg     (mul_neg),
        .sh      (mul_sh),
        .busy    (mul_busy),
        .res     (mul_res)
    );

    thad_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .go       (div_go),
        .rem_init (div_rem),
        .dvd      (div_dvd),
        .dsr      (div_dsr),
        .steps    (div_steps),
        .busy     (div_busy),
        .quo      (div_quo)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_reg <= thad_pkg::REF_RESET;
            ca_reg  <= 48'd0;
            cb_reg  <= 48'd0;
            cc_reg  <= 48'd0;
        end else if (cfg_valid) begin
            unique case (thad_pkg::cfg_idx_t'(cfg_index))
                thad_pkg::CFG_REF: ref_reg <= cfg_data[19:0];
                thad_pkg::CFG_A:   ca_reg  <= cfg_data;
                thad_pkg::CFG_B:   cb_reg  <= cfg_data;
                thad_pkg::CFG_C:   cc_reg  <= cfg_data;
                default:           ref_reg <= ref_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            priming_reg <= 1'b1;
            pend_reg    <= 1'b0;
            run_reg     <= 8'd0;
            src_reg     <= 24'd0;
            therm_reg   <= 16'd0;
            res_reg     <= 36'd0;
            temp_reg    <= 26'd0;
            valid_reg   <= 1'b0;
            compute_reg <= 1'b0;
            mv_reg      <= 1'b0;
        end else begin
            if (cmd.op == thad_pkg::OP_OUT) begin
                mv_reg <= 1'b1;
            end else if (m_tready) begin
                mv_reg <= 1'b0;
            end
            unique case (cmd.op)
                thad_pkg::OP_ACCEPT: begin
                    ok_reg <= in_ok;
                    if (priming_reg) begin
                        chan_reg    <= 1'b1;
                        next_reg    <= !in_ok;
                        compute_reg <= 1'b0;
                        if (in_ok) begin
                            src_reg     <= {sample, 8'd0};
                            priming_reg <= 1'b0;
                            pend_reg    <= 1'b0;
                        end
                    end else begin
                        chan_reg    <= pend_reg;
                        compute_reg <= in_ok;
                        if (!pend_reg && in_ok) begin
                            therm_reg <= sample;
                        end
                        if (pend_reg && in_ok) begin
                            src_reg <= avg_sum[24:1];
                        end
                        if (run_next == thad_pkg::SAMPLES_PER_SOURCE) begin
                            pend_reg <= 1'b1;
                            next_reg <= 1'b1;
                            run_reg  <= 8'd0;
                        end else begin
                            pend_reg <= 1'b0;
                            next_reg <= 1'b0;
                            run_reg  <= run_next;
                        end
                    end
                end
                thad_pkg::OP_CHECK: begin
                    if (compute_reg && (t_zero || s_le)) begin
                        res_reg   <= t_zero ? thad_pkg::RES_MAX : 36'd0;
                        temp_reg  <= 26'd0;
                        valid_reg <= 1'b0;
                    end
                end
                thad_pkg::OP_RSAT: begin
                    res_reg <= r16;
                    x_reg   <= r16;
                    k_reg   <= 6'd35;
                    if (r16 == 36'd0) begin
                        temp_reg  <= 26'd0;
                        valid_reg <= 1'b0;
                    end
                end
                thad_pkg::OP_NORM: begin
                    if (!x_reg[35]) begin
                        x_reg <= {x_reg[34:0], 1'b0};
                        k_reg <= k_reg - 6'd1;
                    end
                end
                thad_pkg::OP_SQLOAD: begin
                    m_reg     <= {1'b0, x_reg[35:5]};
                    frac_reg  <= 24'd0;
                    sqcnt_reg <= 5'd0;
                end
                thad_pkg::OP_SQ: begin
                    m_reg     <= sq_t[31] ? {1'b0, sq_t[31:1]} : sq_t;
                    frac_reg  <= {frac_reg[22:0], sq_t[31]};
                    sqcnt_reg <= sqcnt_reg + 5'd1;
                end
                thad_pkg::OP_L2:  l_reg  <= mul_res;
                thad_pkg::OP_BL:  l3_reg <= mul_res;
                thad_pkg::OP_CL:  p1_reg <= mul_res;
                thad_pkg::OP_SUM: begin
                    d_reg <= d_next;
                    if (d_nonpos) begin
                        temp_reg  <= 26'd0;
                        valid_reg <= 1'b0;
                    end else if (d_small) begin
                        temp_reg  <= thad_pkg::TEMP_MAX;
                        valid_reg <= 1'b1;
                    end
                end
                thad_pkg::OP_TSTORE: begin
                    temp_reg  <= div_quo[25:0];
                    valid_reg <= 1'b1;
                end
                thad_pkg::OP_OUT: begin
                    mdata_reg <= {valid_reg, temp_reg, res_reg, ok_reg};
                    muser_reg <= {next_reg, chan_reg};
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        sts.skip      = !compute_reg || t_zero || s_le;
        sts.mul_busy  = mul_busy;
        sts.div_busy  = div_busy;
        sts.r_zero    = (div_quo == 64'd0);
        sts.norm_done = x_reg[35];
        sts.sq_last   = (sqcnt_reg == thad_pkg::SQ_LAST);
        sts.d_done    = d_nonpos || d_small;
        sts.out_free  = !mv_reg || m_tready;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = muser_reg;

endmodule

// ===== hdl/thad_ctrl.sv =====
`include "thermistor_adc_temperature_macros.svh"

module thad_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  thad_pkg::sts_t  sts,
    output thad_pkg::cmd_t  cmd
);

    thad_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= thad_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            thad_pkg::ST_IDLE:   if (s_tvalid) state_next = thad_pkg::ST_CHECK;
            thad_pkg::ST_CHECK: begin
                state_next = sts.skip ? thad_pkg::ST_OUT : thad_pkg::ST_RMUL;
            end
            thad_pkg::ST_RMUL:   state_next = thad_pkg::ST_RMUL_W;
            thad_pkg::ST_RMUL_W: if (!sts.mul_busy) state_next = thad_pkg::ST_RDIV;
            thad_pkg::ST_RDIV:   state_next = thad_pkg::ST_RDIV_W;
            thad_pkg::ST_RDIV_W: if (!sts.div_busy) state_next = thad_pkg::ST_RSAT;
            thad_pkg::ST_RSAT: begin
                state_next = sts.r_zero ? thad_pkg::ST_OUT : thad_pkg::ST_NORM;
            end
            thad_pkg::ST_NORM:   if (sts.norm_done) state_next = thad_pkg::ST_SQLOAD;
            thad_pkg::ST_SQLOAD: state_next = thad_pkg::ST_SQ;
            thad_pkg::ST_SQ:     if (sts.sq_last) state_next = thad_pkg::ST_LN;
            thad_pkg::ST_LN:     state_next = thad_pkg::ST_LN_W;
            thad_pkg::ST_LN_W:   if (!sts.mul_busy) state_next = thad_pkg::ST_L2;
            thad_pkg::ST_L2:     state_next = thad_pkg::ST_L2_W;
            thad_pkg::ST_L2_W:   if (!sts.mul_busy) state_next = thad_pkg::ST_L3;
            thad_pkg::ST_L3:     state_next = thad_pkg::ST_L3_W;
            thad_pkg::ST_L3_W:   if (!sts.mul_busy) state_next = thad_pkg::ST_BL;
            thad_pkg::ST_BL:     state_next = thad_pkg::ST_BL_W;
            thad_pkg::ST_BL_W:   if (!sts.mul_busy) state_next = thad_pkg::ST_CL;
            thad_pkg::ST_CL:     state_next = thad_pkg::ST_CL_W;
            thad_pkg::ST_CL_W:   if (!sts.mul_busy) state_next = thad_pkg::ST_SUM;
            thad_pkg::ST_SUM: begin
                state_next = sts.d_done ? thad_pkg::ST_OUT : thad_pkg::ST_TDIV;
            end
            thad_pkg::ST_TDIV:   state_next = thad_pkg::ST_TDIV_W;
            thad_pkg::ST_TDIV_W: if (!sts.div_busy) state_next = thad_pkg::ST_TSTORE;
            thad_pkg::ST_TSTORE: state_next = thad_pkg::ST_OUT;
            thad_pkg::ST_OUT:    if (sts.out_free) state_next = thad_pkg::ST_IDLE;
            default:             state_next = thad_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd.op   = thad_pkg::OP_NONE;
        s_tready = 1'b0;
        unique case (state_reg)
            thad_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) cmd.op = thad_pkg::OP_ACCEPT;
            end
            thad_pkg::ST_CHECK:  cmd.op = thad_pkg::OP_CHECK;
            thad_pkg::ST_RMUL:   cmd.op = thad_pkg::OP_RMUL;
            thad_pkg::ST_RDIV:   cmd.op = thad_pkg::OP_RDIV;
            thad_pkg::ST_RSAT:   cmd.op = thad_pkg::OP_RSAT;
            thad_pkg::ST_NORM:   cmd.op = thad_pkg::OP_NORM;
            thad_pkg::ST_SQLOAD: cmd.op = thad_pkg::OP_SQLOAD;
            thad_pkg::ST_SQ:     cmd.op = thad_pkg::OP_SQ;
            thad_pkg::ST_LN:     cmd.op = thad_pkg::OP_LN;
            thad_pkg::ST_L2:     cmd.op = thad_pkg::OP_L2;
            thad_pkg::ST_L3:     cmd.op = thad_pkg::OP_L3;
            thad_pkg::ST_BL:     cmd.op = thad_pkg::OP_BL;
            thad_pkg::ST_CL:     cmd.op = thad_pkg::OP_CL;
            thad_pkg::ST_SUM:    cmd.op = thad_pkg::OP_SUM;
            thad_pkg::ST_TDIV:   cmd.op = thad_pkg::OP_TDIV;
            thad_pkg::ST_TSTORE: cmd.op = thad_pkg::OP_TSTORE;
            thad_pkg::ST_OUT:    if (sts.out_free) cmd.op = thad_pkg::OP_OUT;
            default:             cmd.op = thad_pkg::OP_NONE;
        endcase
    end

    `THAD_ASSERT_HOLD(a_accept_valid, (cmd.op != thad_pkg::OP_ACCEPT) || s_tvalid, "accept without beat")
    `THAD_ASSERT_NEXT(a_accept_check, s_tvalid && s_tready, state_reg == thad_pkg::ST_CHECK, "no check after beat")
    `THAD_ASSERT_NEXT(a_mul_start, cmd.op == thad_pkg::OP_RMUL || cmd.op == thad_pkg::OP_LN, sts.mul_busy, "multiplier did not start")
    `THAD_ASSERT_NEXT(a_div_start, cmd.op == thad_pkg::OP_RDIV || cmd.op == thad_pkg::OP_TDIV, sts.div_busy, "divider did not start")

endmodule
